// File: rtl/cbr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the B-spline resampler.
package cbr_pkg;

  localparam int COEF_DEPTH  = 262144;
  localparam int COEF_AW     = $clog2(COEF_DEPTH);
  localparam int DIM_MAX     = 64;
  localparam int OUT_DIM_MAX = 1024;
  localparam int MAT_N       = 12;

  localparam int DIM_W = $clog2(DIM_MAX + 1);
  localparam int IB_W  = $clog2(DIM_MAX);
  localparam int AD_W  = 3 * DIM_W;

  localparam logic [1:0] REQ_LOAD_COEF = 2'd0;
  localparam logic [1:0] REQ_LOAD_MAT  = 2'd1;
  localparam logic [1:0] REQ_PIXEL     = 2'd2;

  localparam logic [2:0] CFG_DIM_X   = 3'd0;
  localparam logic [2:0] CFG_DIM_Y   = 3'd1;
  localparam logic [2:0] CFG_DIM_Z   = 3'd2;
  localparam logic [2:0] CFG_ORD_X   = 3'd3;
  localparam logic [2:0] CFG_ORD_Y   = 3'd4;
  localparam logic [2:0] CFG_ORD_Z   = 3'd5;
  localparam logic [2:0] CFG_SLICE   = 3'd6;

  localparam logic [1:0] ORD_VALUE  = 2'd0;
  localparam logic [1:0] ORD_FIRST  = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;
  localparam logic [1:0] ORD_BAD    = 2'd3;

  localparam int COORD_STEPS = 12;
  localparam int WGT_STEPS   = 12;
  localparam int WGT_DRAIN   = 2;
  localparam int TAP_STEPS   = 64;
  localparam int TAP_DRAIN   = 4;

  typedef struct packed {
    logic       load_coef;
    logic       load_mat;
    logic       capture;
    logic       coord_en;
    logic [1:0] coord_axis;
    logic [1:0] coord_term;
    logic       check;
    logic       wgt_en;
    logic [3:0] wgt_idx;
    logic       tap_en;
    logic [5:0] tap_idx;
    logic       acc_clr;
    logic       finish;
    logic       reject;
  } cbr_cmd_t;

  typedef struct packed {
    logic early_bad;
    logic in_range;
  } cbr_stat_t;

endpackage

// File: rtl/cubic_bspline_resample_3d.sv
// Top level of the cubic B-spline affine resampler of a 3D coefficient volume.
//
//   channel   direction  handshake                     payload
//   cfg       in         cfg_we_i                      cfg_idx_i, cfg_data_i
//   request   in         in_valid_i / in_stall_o       req_type_i, addr_i, load_value_i,
//                                                      col_index_i, row_index_i
//   result    out        out_valid_o / out_stall_i     pixel_value_o, outside_flag_o
//
// A load request is written in the cycle it is accepted and gives no result. A pixel request uses
// 12 affine products on one multiplier, 12 kernel weights, and 64 taps read one per
// cycle from the single-port coefficient memory through a five-stage MAC pipe.
// A rejected request skips the weight and tap phases. One request is in work at
// a time; the request side stalls until the result has been taken.
// Reset initialises control state and configuration; both stores are undefined until loaded.
module cubic_bspline_resample_3d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [17:0]        addr_i,
  input  logic signed [31:0] load_value_i,
  input  logic [9:0]         col_index_i,
  input  logic [9:0]         row_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pixel_value_o,
  output logic               outside_flag_o
);
  import cbr_pkg::*;

  cbr_cmd_t  cmd;
  cbr_stat_t stat;

  cbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cbr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .addr_i         (addr_i),
    .load_value_i   (load_value_i),
    .col_index_i    (col_index_i),
    .row_index_i    (row_index_i),
    .pixel_value_o  (pixel_value_o),
    .outside_flag_o (outside_flag_o)
  );

endmodule

// File: rtl/cbr_ctrl.sv
// Sequencing state machine of the B-spline resampler.
module cbr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  cbr_pkg::cbr_stat_t stat_i,
  output cbr_pkg::cbr_cmd_t  cmd_o
);
  import cbr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_COORD, S_CHECK, S_DECIDE, S_WGT, S_TAP, S_FINISH, S_OUT
  } state_e;

  localparam logic [6:0] COORD_LAST = 7'(COORD_STEPS - 1);
  localparam logic [6:0] WGT_LAST   = 7'(WGT_STEPS + WGT_DRAIN - 1);
  localparam logic [6:0] TAP_LAST   = 7'(TAP_STEPS + TAP_DRAIN - 1);

  state_e     state_q;
  logic [6:0] cnt_q;
  logic       out_valid_q;
  logic       in_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.coord_axis = cnt_q[3:2];
    cmd_o.coord_term = cnt_q[1:0];
    cmd_o.wgt_idx    = cnt_q[3:0];
    cmd_o.tap_idx    = cnt_q[5:0];
    case (state_q)
      S_IDLE: begin
        cmd_o.load_coef = in_acc && (req_type_i == REQ_LOAD_COEF);
        cmd_o.load_mat  = in_acc && (req_type_i == REQ_LOAD_MAT);
        cmd_o.capture   = in_acc && (req_type_i == REQ_PIXEL);
      end
      S_START:  cmd_o.reject = stat_i.early_bad;
      S_COORD:  cmd_o.coord_en = 1'b1;
      S_CHECK:  cmd_o.check = 1'b1;
      S_DECIDE: begin
        cmd_o.reject  = !stat_i.in_range;
        cmd_o.acc_clr = stat_i.in_range;
      end
      S_WGT:    cmd_o.wgt_en = (cnt_q < 7'(WGT_STEPS));
      S_TAP:    cmd_o.tap_en = (cnt_q < 7'(TAP_STEPS));
      S_FINISH: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc && (req_type_i == REQ_PIXEL)) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          cnt_q <= '0;
          if (stat_i.early_bad) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= S_COORD;
          end
        end
        S_COORD: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == COORD_LAST) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK:  state_q <= S_DECIDE;
        S_DECIDE: begin
          cnt_q <= '0;
          if (!stat_i.in_range) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= S_WGT;
          end
        end
        S_WGT: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == WGT_LAST) begin
            cnt_q   <= '0;
            state_q <= S_TAP;
          end
        end
        S_TAP: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == TAP_LAST) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          state_q     <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/cbr_dp.sv
// Datapath: configuration, matrix and coefficient stores, affine map, kernel unit and tap MAC pipe.
module cbr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbr_pkg::cbr_cmd_t   cmd_i,
  output cbr_pkg::cbr_stat_t  stat_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [9:0]          cfg_data_i,
  input  logic [17:0]         addr_i,
  input  logic signed [31:0]  load_value_i,
  input  logic [9:0]          col_index_i,
  input  logic [9:0]          row_index_i,
  output logic signed [31:0]  pixel_value_o,
  output logic                outside_flag_o
);
  import cbr_pkg::*;

  localparam logic [17:0] Q1 = 18'd65536;
  localparam logic [17:0] Q2 = 18'd131072;
  localparam logic signed [44:0] LOW_LIM = -45'sd32768;
  localparam logic signed [44:0] LIM_OFS = 45'sd163840;
  localparam logic [52:0] K_FOURQ3 = 53'd1 << 50;
  localparam logic [52:0] K_THREEQ2 = 53'd3 << 32;
  localparam logic [42:0] RECIP6 = 43'd2796203;
  localparam logic signed [59:0] SAT_HI = 60'sd2147483647;
  localparam logic signed [59:0] SAT_LO = -60'sd2147483648;

  // Configuration.
  logic [6:0] dim_q [3];
  logic [1:0] ord_q [3];
  logic [9:0] slice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q[0] <= 7'(DIM_MAX);
      dim_q[1] <= 7'(DIM_MAX);
      dim_q[2] <= 7'(DIM_MAX);
      ord_q[0] <= ORD_VALUE;
      ord_q[1] <= ORD_VALUE;
      ord_q[2] <= ORD_VALUE;
      slice_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM_X: dim_q[0] <= cfg_data_i[6:0];
        CFG_DIM_Y: dim_q[1] <= cfg_data_i[6:0];
        CFG_DIM_Z: dim_q[2] <= cfg_data_i[6:0];
        CFG_ORD_X: ord_q[0] <= cfg_data_i[1:0];
        CFG_ORD_Y: ord_q[1] <= cfg_data_i[1:0];
        CFG_ORD_Z: ord_q[2] <= cfg_data_i[1:0];
        CFG_SLICE: slice_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] de [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      de[a] = (32'(dim_q[a]) > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(dim_q[a]);
    end
  end

  // Request capture and early rejection.
  logic [9:0] ci_q, rj_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ci_q <= col_index_i;
      rj_q <= row_index_i;
    end
  end

  assign stat_o.early_bad = (ord_q[0] == ORD_BAD) || (ord_q[1] == ORD_BAD) ||
                            (ord_q[2] == ORD_BAD) || (32'(ci_q) >= OUT_DIM_MAX) ||
                            (32'(rj_q) >= OUT_DIM_MAX) || (32'(slice_q) >= OUT_DIM_MAX);

  // Affine map, one product per cycle.
  logic signed [31:0] mat_q [MAT_N];
  logic signed [44:0] c_q [3];
  logic        [3:0]  mat_idx;
  logic signed [10:0] opnd;
  logic signed [42:0] cprod;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mat && (32'(addr_i) < MAT_N)) begin
      mat_q[addr_i[3:0]] <= load_value_i;
    end
  end

  assign mat_idx = {cmd_i.coord_axis, cmd_i.coord_term};

  always_comb begin
    case (cmd_i.coord_term)
      2'd0:    opnd = $signed({1'b0, ci_q});
      2'd1:    opnd = $signed({1'b0, rj_q});
      2'd2:    opnd = $signed({1'b0, slice_q});
      default: opnd = 11'sd1;
    endcase
    cprod = mat_q[mat_idx] * opnd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_en) begin
      c_q[cmd_i.coord_axis] <= ((cmd_i.coord_term == 2'd0) ? 45'sd0 : c_q[cmd_i.coord_axis])
                               + 45'(cprod);
    end
  end

  // Range check, base index and fraction per axis.
  logic [IB_W-1:0]   ib_q [3];
  logic [15:0]       f_q [3];
  logic              inside_q;
  logic [2:0]        in_ax;
  logic signed [44:0] lim [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lim[a]   = $signed({22'd0, de[a], 16'd0}) - LIM_OFS;
      in_ax[a] = (c_q[a] >= LOW_LIM) && (c_q[a] <= lim[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      inside_q <= &in_ax;
      for (int a = 0; a < 3; a++) begin
        ib_q[a] <= c_q[a][44] ? '0 : c_q[a][16+IB_W-1:16];
        f_q[a]  <= c_q[a][44] ? '0 : c_q[a][15:0];
      end
    end
  end

  assign stat_o.in_range = inside_q;

  // Kernel unit, three stages, one weight issued per cycle.
  logic [1:0]  kax, ktap, kord;
  logic [15:0] kf;
  logic [17:0] ka;
  logic [16:0] kb;
  logic        knear;

  assign kax  = cmd_i.wgt_idx[3:2];
  assign ktap = cmd_i.wgt_idx[1:0];
  assign kf   = f_q[kax];
  assign kord = ord_q[kax];

  always_comb begin
    case (ktap)
      2'd0:    ka = 18'(kf) + Q1;
      2'd1:    ka = 18'(kf);
      2'd2:    ka = Q1 - 18'(kf);
      default: ka = Q2 - 18'(kf);
    endcase
    knear = ka < Q1;
    kb    = knear ? ka[16:0] : 17'(Q2 - ka);
  end

  logic        k1_v, k2_v;
  logic [3:0]  k1_idx, k2_idx;
  logic [1:0]  k1_ord, k2_ord;
  logic        k1_neg, k2_neg, k1_near, k2_near, k1_zero, k2_zero;
  logic [17:0] k1_a, k2_a;
  logic [16:0] k1_b;
  logic [33:0] k1_sq;
  logic [52:0] k2_n, kcube, kn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_v <= 1'b0;
      k2_v <= 1'b0;
    end else begin
      k1_v <= cmd_i.wgt_en;
      k2_v <= k1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_idx  <= cmd_i.wgt_idx;
    k1_ord  <= kord;
    k1_neg  <= ktap[1];
    k1_near <= knear;
    k1_zero <= ka >= Q2;
    k1_a    <= ka;
    k1_b    <= kb;
    k1_sq   <= 34'(kb) * 34'(kb);
  end

  always_comb begin
    kcube = 53'(k1_sq) * 53'(k1_b);
    case (k1_ord)
      ORD_VALUE: kn = k1_near ? (K_FOURQ3 + 53'd3 * kcube) - ((53'd6 * 53'(k1_sq)) << 16)
                              : kcube;
      ORD_FIRST: kn = k1_near ? (53'(k1_a) << 18) - 53'd3 * 53'(k1_sq) : 53'(k1_sq);
      default:   kn = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    k2_idx  <= k1_idx;
    k2_ord  <= k1_ord;
    k2_neg  <= k1_neg;
    k2_near <= k1_near;
    k2_zero <= k1_zero;
    k2_a    <= k1_a;
    k2_n    <= kn;
  end

  logic [52:0]        kv_sum, km_sum;
  logic [42:0]        kdiv;
  logic [17:0]        kmag;
  logic signed [19:0] k2nd;
  logic signed [17:0] kw;

  always_comb begin
    kv_sum = k2_n + K_THREEQ2;
    km_sum = k2_n + 53'(Q1);
    kdiv   = 43'(kv_sum[52:32]) * RECIP6;
    kmag   = 18'(km_sum[52:17]);
    k2nd   = k2_near ? $signed(20'(3 * 20'(k2_a))) - $signed(20'(Q2))
                     : $signed(20'(Q2)) - $signed(20'(k2_a));
    case (k2_ord)
      ORD_VALUE:  kw = $signed(18'(kdiv[42:24]));
      ORD_FIRST:  kw = k2_neg ? $signed(kmag) : -$signed(kmag);
      ORD_SECOND: kw = 18'(k2nd);
      default:    kw = '0;
    endcase
    if (k2_zero) begin
      kw = '0;
    end
  end

  logic signed [17:0] wx_q [4], wy_q [4], wz_q [4];
  always_ff @(posedge clk_i) begin
    if (k2_v) begin
      case (k2_idx[3:2])
        2'd0:    wx_q[k2_idx[1:0]] <= kw;
        2'd1:    wy_q[k2_idx[1:0]] <= kw;
        default: wz_q[k2_idx[1:0]] <= kw;
      endcase
    end
  end

  // Tap pipe: address and weight products, coefficient read, MAC.
  logic [1:0]       tl, tm, tn;
  logic [DIM_W-1:0] zz, yy, xx;
  logic             tskip;

  assign tl = cmd_i.tap_idx[5:4];
  assign tm = cmd_i.tap_idx[3:2];
  assign tn = cmd_i.tap_idx[1:0];
  assign zz = DIM_W'(ib_q[2]) + DIM_W'(tl);
  assign yy = DIM_W'(ib_q[1]) + DIM_W'(tm);
  assign xx = DIM_W'(ib_q[0]) + DIM_W'(tn);
  assign tskip = (zz >= de[2]) || (yy >= de[1]) || (xx >= de[0]);

  logic                 t1_v, t2_v, t3_v, t4_v;
  logic                 t1_skip, t2_skip, t3_skip, t4_skip;
  logic [2*DIM_W-1:0]   t1_p;
  logic [DIM_W-1:0]     t1_xx;
  logic [1:0]           t1_n, t2_n;
  logic signed [35:0]   t1_wzy, wzy_r;
  logic [AD_W-1:0]      t2_addr, addr_c;
  logic signed [19:0]   t2_wyz;
  logic signed [37:0]   t3_prod2, p2_r;
  logic signed [21:0]   wxyz;
  logic signed [53:0]   t4_prod;
  logic signed [31:0]   coef_q;
  logic signed [59:0]   acc_q, acc_r;
  logic signed [31:0]   coef_mem [COEF_DEPTH];
  logic [COEF_AW-1:0]   mem_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
      t4_v <= 1'b0;
    end else begin
      t1_v <= cmd_i.tap_en;
      t2_v <= t1_v;
      t3_v <= t2_v;
      t4_v <= t3_v;
    end
  end

  assign addr_c = AD_W'(t1_p) * AD_W'(de[0]) + AD_W'(t1_xx);
  assign wzy_r  = t1_wzy + 36'sd32768;
  assign p2_r   = t3_prod2 + 38'sd32768;
  assign wxyz   = 22'(p2_r >>> 16);

  always_ff @(posedge clk_i) begin
    t1_skip  <= tskip;
    t1_p     <= (2*DIM_W)'(zz) * (2*DIM_W)'(de[1]) + (2*DIM_W)'(yy);
    t1_xx    <= xx;
    t1_n     <= tn;
    t1_wzy   <= wz_q[tl] * wy_q[tm];
    t2_addr  <= addr_c;
    t2_skip  <= t1_skip || (32'(addr_c) >= COEF_DEPTH);
    t2_wyz   <= 20'(wzy_r >>> 16);
    t2_n     <= t1_n;
    t3_prod2 <= wx_q[t2_n] * t2_wyz;
    t3_skip  <= t2_skip;
    t4_prod  <= coef_q * wxyz;
    t4_skip  <= t3_skip;
  end

  assign mem_addr = cmd_i.load_coef ? addr_i[COEF_AW-1:0] : t2_addr[COEF_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coef) begin
      if (32'(addr_i) < COEF_DEPTH) begin
        coef_mem[mem_addr] <= load_value_i;
      end
    end else begin
      coef_q <= coef_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (t4_v && !t4_skip) begin
      acc_q <= acc_q + 60'(t4_prod);
    end
  end

  // Rounding, saturation and result register.
  logic signed [59:0] rres;
  assign acc_r = acc_q + 60'sd32768;
  assign rres  = acc_r >>> 16;

  always_ff @(posedge clk_i) begin
    if (cmd_i.reject) begin
      pixel_value_o  <= '0;
      outside_flag_o <= 1'b1;
    end else if (cmd_i.finish) begin
      outside_flag_o <= 1'b0;
      if (rres > SAT_HI) begin
        pixel_value_o <= 32'sh7FFFFFFF;
      end else if (rres < SAT_LO) begin
        pixel_value_o <= 32'sh80000000;
      end else begin
        pixel_value_o <= 32'(rres);
      end
    end
  end

endmodule

// File: rtl/cbr_chk.sv
// Port-level checker for the B-spline resampler, bound to the top level.
module cbr_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [2:0]         cfg_idx_i,
  input logic [9:0]         cfg_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         req_type_i,
  input logic [17:0]        addr_i,
  input logic signed [31:0] load_value_i,
  input logic [9:0]         col_index_i,
  input logic [9:0]         row_index_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] pixel_value_o,
  input logic               outside_flag_o
);
  import cbr_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o) &&
    $stable(outside_flag_o))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_PIXEL) |=> in_stall_o)
    else $error("pixel request did not make the block busy");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_LOAD_COEF || req_type_i == REQ_LOAD_MAT)
    |=> !out_valid_o)
    else $error("load request produced a result");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outside_flag_o |-> pixel_value_o == 32'sd0)
    else $error("outside result is not zero");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while a result is pending");

endmodule

bind cubic_bspline_resample_3d cbr_chk u_chk (.*);
